/* rtl/core/framed_crc8_led_receiver_defines.svh */
// Assertion macros shared by the receiver RTL.
`ifndef FRAMED_CRC8_LED_RECEIVER_DEFINES_SVH
`define FRAMED_CRC8_LED_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framed_crc8_led_receiver: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framed_crc8_led_receiver: assertion failed");

`endif

/* rtl/core/fcl_pkg.sv */
package fcl_pkg;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] STOP_BYTE  = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_FRAME_OK = 3'd1;
    localparam logic [2:0] ST_CRC_ERR  = 3'd2;
    localparam logic [2:0] ST_STOP_ERR = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 1'b1;

    localparam logic        UNIT_SELECT_RST = 1'b1;
    localparam logic [15:0] TIMEOUT_MS_RST  = 16'd500;

    typedef struct packed {
        logic       accept;
        logic       crc_err;
        logic       stop_err;
        logic [7:0] sel_data;
    } t_frame_evt;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

/* rtl/core/fcl_parser.sv */
module fcl_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_cmd,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_unit_select,
    output fcl_pkg::t_frame_evt   o_evt
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_D1    = 3'd1;
    localparam logic [2:0] PH_D2    = 3'd2;
    localparam logic [2:0] PH_CRC   = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic [7:0] r_first;
    logic [7:0] r_second;
    logic [7:0] r_crc_acc;
    logic [7:0] r_frame_crc;
    logic       w_is_byte;
    logic       w_at_end;
    logic       w_stop_ok;
    logic       w_crc_ok;

    assign w_is_byte = !i_cmd;
    assign w_at_end  = w_is_byte && (r_phase == PH_END);
    assign w_stop_ok = (i_rx_byte == fcl_pkg::STOP_BYTE);
    assign w_crc_ok  = (r_crc_acc == r_frame_crc);

    always_comb begin
        o_evt.accept   = w_at_end && w_stop_ok && w_crc_ok;
        o_evt.crc_err  = w_at_end && w_stop_ok && !w_crc_ok;
        o_evt.stop_err = w_at_end && !w_stop_ok;
        o_evt.sel_data = i_unit_select ? r_second : r_first;
    end

    always_comb begin
        n_phase = r_phase;
        if (w_is_byte) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_rx_byte == fcl_pkg::START_BYTE) begin
                        n_phase = PH_D1;
                    end
                end
                PH_D1:   n_phase = PH_D2;
                PH_D2:   n_phase = PH_CRC;
                PH_CRC:  n_phase = PH_END;
                default: n_phase = PH_START;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    // The CRC is built up one data byte at a time as the frame arrives.
    always_ff @(posedge i_clk) begin
        if (i_fire && w_is_byte) begin
            if (r_phase == PH_D1) begin
                r_first   <= i_rx_byte;
                r_crc_acc <= fcl_pkg::crc8_byte(8'h00, i_rx_byte);
            end
            if (r_phase == PH_D2) begin
                r_second  <= i_rx_byte;
                r_crc_acc <= fcl_pkg::crc8_byte(r_crc_acc, i_rx_byte);
            end
            if (r_phase == PH_CRC) begin
                r_frame_crc <= i_rx_byte;
            end
        end
    end

endmodule

/* rtl/core/fcl_led_ctrl.sv */
module fcl_led_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_cmd,
    input  fcl_pkg::t_frame_evt   i_evt,
    input  logic [15:0]           i_timeout_ms,
    output logic [7:0]            o_led_pattern,
    output logic                  o_error_flag,
    output logic [2:0]            o_status
);

    logic [7:0]  r_pattern;
    logic        r_lit;
    logic [15:0] r_elapsed;
    logic        r_error;
    logic [7:0]  n_pattern;
    logic        n_lit;
    logic [15:0] n_elapsed;
    logic        n_error;
    logic [2:0]  n_status;

    always_comb begin
        n_pattern = r_pattern;
        n_lit     = r_lit;
        n_elapsed = r_elapsed;
        n_error   = r_error;
        n_status  = fcl_pkg::ST_NONE;

        unique if (i_evt.accept) begin
            n_pattern = i_evt.sel_data;
            n_lit     = |i_evt.sel_data;
            n_elapsed = '0;
            n_error   = 1'b0;
            n_status  = fcl_pkg::ST_FRAME_OK;
        end else if (i_evt.crc_err) begin
            n_error  = 1'b1;
            n_status = fcl_pkg::ST_CRC_ERR;
        end else if (i_evt.stop_err) begin
            n_error  = 1'b1;
            n_status = fcl_pkg::ST_STOP_ERR;
        end else begin
        end

        if (i_cmd && (r_elapsed != '1)) begin
            n_elapsed = r_elapsed + 16'd1;
        end

        if (n_lit && (n_elapsed > i_timeout_ms)) begin
            n_pattern = '0;
            n_lit     = 1'b0;
            n_elapsed = '0;
            if (n_status == fcl_pkg::ST_NONE) begin
                n_status = fcl_pkg::ST_TIMEOUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_lit     <= 1'b0;
            r_elapsed <= '0;
            r_error   <= 1'b0;
        end else if (i_fire) begin
            r_pattern <= n_pattern;
            r_lit     <= n_lit;
            r_elapsed <= n_elapsed;
            r_error   <= n_error;
        end
    end

    assign o_led_pattern = n_pattern;
    assign o_error_flag  = n_error;
    assign o_status      = n_status;

endmodule

/* rtl/core/framed_crc8_led_receiver.sv */
// Path: an accepted item waits in the input register, then its result is registered
// in the result register and held on the output while the output stall is high.
// Throughput: one item per cycle unless stalled, set by input and result registers.
// Reset: synchronous, active low; clears the parser to waiting for a start byte,
// the LED pattern, elapsed counter and error flag, and loads the register defaults.
`include "framed_crc8_led_receiver_defines.svh"

module framed_crc8_led_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_led_pattern,
    output logic                           o_error_flag,
    output logic [2:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fcl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_unit_select;
    logic [15:0]         r_timeout_ms;
    logic                r_in_valid;
    logic                r_in_cmd;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    logic [7:0]          r_out_led;
    logic                r_out_err;
    logic [2:0]          r_out_status;
    logic                w_out_free;
    logic                w_fire;
    fcl_pkg::t_frame_evt w_evt;
    logic [7:0]          w_led;
    logic                w_err;
    logic [2:0]          w_status;
    logic                w_shows_ok;
    logic                w_shows_err;
    logic                w_shows_timeout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_select <= fcl_pkg::UNIT_SELECT_RST;
            r_timeout_ms  <= fcl_pkg::TIMEOUT_MS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fcl_pkg::REG_UNIT_SELECT: r_unit_select <= i_cfg_data[0];
                fcl_pkg::REG_TIMEOUT_MS:  r_timeout_ms  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_rx_byte;
        end
    end

    fcl_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_cmd         (r_in_cmd),
        .i_rx_byte     (r_in_byte),
        .i_unit_select (r_unit_select),
        .o_evt         (w_evt)
    );

    fcl_led_ctrl u_led_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_cmd         (r_in_cmd),
        .i_evt         (w_evt),
        .i_timeout_ms  (r_timeout_ms),
        .o_led_pattern (w_led),
        .o_error_flag  (w_err),
        .o_status      (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_led    <= w_led;
            r_out_err    <= w_err;
            r_out_status <= w_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_pattern = r_out_led;
    assign o_error_flag  = r_out_err;
    assign o_status      = r_out_status;

    assign w_shows_ok      = o_out_valid && (o_status == fcl_pkg::ST_FRAME_OK);
    assign w_shows_err     = o_out_valid && ((o_status == fcl_pkg::ST_CRC_ERR) ||
                                             (o_status == fcl_pkg::ST_STOP_ERR));
    assign w_shows_timeout = o_out_valid && (o_status == fcl_pkg::ST_TIMEOUT);

    `FCL_ASSERT_IMPLY(a_ok_clears_err, i_clk, i_rst_n, w_shows_ok, !o_error_flag)
    `FCL_ASSERT_IMPLY(a_err_sets_flag, i_clk, i_rst_n, w_shows_err, o_error_flag)
    `FCL_ASSERT_IMPLY(a_timeout_dark, i_clk, i_rst_n, w_shows_timeout, o_led_pattern == 8'h00)
    `FCL_ASSERT_IMPLY(a_stall_has_items, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)
    `FCL_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_out_valid)

endmodule
